FILE: design/fra_pkg.sv
// ----------------------------------------------------------------------------
// fra_pkg
// Status codes, opcodes and shared types of the free range table allocator.
// ----------------------------------------------------------------------------
package fra_pkg;

    typedef logic [1:0] t_status;

    localparam t_status ST_OK         = 2'd0;
    localparam t_status ST_NOT_INSIDE = 2'd1;
    localparam t_status ST_OVERLAP    = 2'd2;
    localparam t_status ST_FULL       = 2'd3;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam int CFG_BITS = 17;

    typedef struct packed {
        logic    done;
        t_status status;
    } t_result;

endpackage

FILE: design/fra_mem.sv
// ----------------------------------------------------------------------------
// fra_mem
// Range table storage: one write port and one read port, registered read.
// ----------------------------------------------------------------------------
module fra_mem #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 33
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/fra_seq.sv
// ----------------------------------------------------------------------------
// fra_seq
// Request sequencer: scans the range table, decides the update, and shifts
// entries up or down through the table memory.
// ----------------------------------------------------------------------------
module fra_seq #(
    parameter int MAX_RANGES = 16,
    parameter int ADDR_BITS  = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic                              i_opcode,
    input  logic [ADDR_BITS-1:0]              i_start_addr,
    input  logic [ADDR_BITS:0]                i_length,
    input  logic [ADDR_BITS:0]                i_total,
    input  logic                              i_cfg_we,
    input  logic [ADDR_BITS:0]                i_cfg_total,
    input  logic                              i_out_free,
    output logic                              o_idle,
    output fra_pkg::t_result                  o_result,
    output logic [$clog2(MAX_RANGES+1)-1:0]   o_count
);

    import fra_pkg::*;

    localparam int AW = ADDR_BITS;
    localparam int LW = ADDR_BITS + 1;
    localparam int XW = ADDR_BITS + 2;
    localparam int IW = $clog2(MAX_RANGES);
    localparam int CW = $clog2(MAX_RANGES + 1);
    localparam int EW = AW + LW;

    localparam logic [3:0] S_INIT  = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_SCAN  = 4'd2;
    localparam logic [3:0] S_SHD_R = 4'd3;
    localparam logic [3:0] S_SHD_W = 4'd4;
    localparam logic [3:0] S_SHU_R = 4'd5;
    localparam logic [3:0] S_SHU_W = 4'd6;
    localparam logic [3:0] S_INS_W = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;

    logic [3:0]    r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic          r_op, n_op;
    logic [AW-1:0] r_s, n_s;
    logic [LW-1:0] r_len, n_len;
    logic [XW-1:0] r_e, n_e;
    logic [CW-1:0] r_idx, n_idx;
    logic          r_has_prev, n_has_prev;
    logic [AW-1:0] r_prev_start, n_prev_start;
    logic [LW-1:0] r_prev_len, n_prev_len;
    logic [LW-1:0] r_prev_end, n_prev_end;
    t_status       r_status, n_status;
    logic [CW-1:0] r_pos, n_pos;
    logic [CW-1:0] r_src, n_src;
    logic [EW-1:0] r_ins, n_ins;

    logic          we;
    logic [IW-1:0] waddr;
    logic [EW-1:0] wdata;
    logic [IW-1:0] raddr;
    logic [EW-1:0] rdata;

    logic [AW-1:0] cur_start;
    logic [LW-1:0] cur_len;
    logic [LW-1:0] cur_end;
    logic          at_end;
    logic          stop;
    logic [XW-1:0] s_x;
    logic [XW-1:0] pend_x;
    logic [XW-1:0] cur_x;
    logic [LW+1:0] sum3;

    fra_mem #(
        .DEPTH (MAX_RANGES),
        .WIDTH (EW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign cur_start = rdata[EW-1:LW];
    assign cur_len   = rdata[LW-1:0];
    assign cur_end   = LW'({1'b0, cur_start} + cur_len);
    assign at_end    = (r_idx == r_count);
    assign stop      = at_end || ((r_op == OP_FREE) ? (r_s <= cur_start) : (r_s < cur_start));
    assign s_x       = XW'(r_s);
    assign pend_x    = XW'(r_prev_end);
    assign cur_x     = XW'(cur_start);
    assign sum3      = (LW+2)'(r_prev_len) + (LW+2)'(r_len) + (LW+2)'(cur_len);

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_op         = r_op;
        n_s          = r_s;
        n_len        = r_len;
        n_e          = r_e;
        n_idx        = r_idx;
        n_has_prev   = r_has_prev;
        n_prev_start = r_prev_start;
        n_prev_len   = r_prev_len;
        n_prev_end   = r_prev_end;
        n_status     = r_status;
        n_pos        = r_pos;
        n_src        = r_src;
        n_ins        = r_ins;
        we           = 1'b0;
        waddr        = '0;
        wdata        = '0;
        raddr        = IW'(r_idx + CW'(1));

        case (r_state)
            S_INIT: begin
                we      = 1'b1;
                wdata   = {{AW{1'b0}}, i_total};
                n_state = S_IDLE;
            end
            S_IDLE: begin
                raddr = '0;
                if (i_cfg_we) begin
                    we      = 1'b1;
                    wdata   = {{AW{1'b0}}, i_cfg_total};
                    n_count = (i_cfg_total == '0) ? CW'(0) : CW'(1);
                end else if (i_start) begin
                    n_op       = i_opcode;
                    n_s        = i_start_addr;
                    n_len      = i_length;
                    n_e        = XW'(i_start_addr) + XW'(i_length);
                    n_idx      = '0;
                    n_has_prev = 1'b0;
                    if (i_length == '0) begin
                        n_status = ST_NOT_INSIDE;
                        n_state  = S_DONE;
                    end else if (i_opcode == OP_FREE &&
                                 (XW'(i_start_addr) + XW'(i_length)) > XW'(i_total)) begin
                        n_status = ST_NOT_INSIDE;
                        n_state  = S_DONE;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (!stop) begin
                    n_prev_start = cur_start;
                    n_prev_len   = cur_len;
                    n_prev_end   = cur_end;
                    n_has_prev   = 1'b1;
                    n_idx        = r_idx + CW'(1);
                end else if (r_op == OP_ALLOC) begin
                    waddr = IW'(r_idx - CW'(1));
                    if (!(r_has_prev && s_x < pend_x && r_e <= pend_x)) begin
                        n_status = ST_NOT_INSIDE;
                        n_state  = S_DONE;
                    end else if (r_s == r_prev_start && r_e == pend_x) begin
                        n_src   = r_idx;
                        n_state = S_SHD_R;
                    end else if (r_s == r_prev_start) begin
                        we       = 1'b1;
                        wdata    = {r_e[AW-1:0], LW'(r_prev_len - r_len)};
                        n_status = ST_OK;
                        n_state  = S_DONE;
                    end else if (r_e == pend_x) begin
                        we       = 1'b1;
                        wdata    = {r_prev_start, LW'(r_prev_len - r_len)};
                        n_status = ST_OK;
                        n_state  = S_DONE;
                    end else if (r_count == CW'(MAX_RANGES)) begin
                        n_status = ST_FULL;
                        n_state  = S_DONE;
                    end else begin
                        we    = 1'b1;
                        wdata = {r_prev_start, LW'(r_s - r_prev_start)};
                        n_pos = r_idx;
                        n_ins = {r_e[AW-1:0], LW'(pend_x - r_e)};
                        n_src = r_count - CW'(1);
                        n_state = (r_idx == r_count) ? S_INS_W : S_SHU_R;
                    end
                end else begin
                    if ((r_has_prev && pend_x > s_x) || (!at_end && r_e > cur_x)) begin
                        n_status = ST_OVERLAP;
                        n_state  = S_DONE;
                    end else if (r_has_prev && pend_x == s_x && !at_end && r_e == cur_x) begin
                        we      = 1'b1;
                        waddr   = IW'(r_idx - CW'(1));
                        wdata   = {r_prev_start, LW'(sum3)};
                        n_src   = r_idx + CW'(1);
                        n_state = S_SHD_R;
                    end else if (r_has_prev && pend_x == s_x) begin
                        we       = 1'b1;
                        waddr    = IW'(r_idx - CW'(1));
                        wdata    = {r_prev_start, LW'(r_prev_len + r_len)};
                        n_status = ST_OK;
                        n_state  = S_DONE;
                    end else if (!at_end && r_e == cur_x) begin
                        we       = 1'b1;
                        waddr    = IW'(r_idx);
                        wdata    = {r_s, LW'(cur_len + r_len)};
                        n_status = ST_OK;
                        n_state  = S_DONE;
                    end else if (r_count == CW'(MAX_RANGES)) begin
                        n_status = ST_FULL;
                        n_state  = S_DONE;
                    end else begin
                        n_pos   = r_idx;
                        n_ins   = {r_s, r_len};
                        n_src   = r_count - CW'(1);
                        n_state = (r_idx == r_count) ? S_INS_W : S_SHU_R;
                    end
                end
            end
            S_SHD_R: begin
                raddr = IW'(r_src);
                if (r_src >= r_count) begin
                    n_count  = r_count - CW'(1);
                    n_status = ST_OK;
                    n_state  = S_DONE;
                end else begin
                    n_state = S_SHD_W;
                end
            end
            S_SHD_W: begin
                we      = 1'b1;
                waddr   = IW'(r_src - CW'(1));
                wdata   = rdata;
                n_src   = r_src + CW'(1);
                n_state = S_SHD_R;
            end
            S_SHU_R: begin
                raddr   = IW'(r_src);
                n_state = S_SHU_W;
            end
            S_SHU_W: begin
                we    = 1'b1;
                waddr = IW'(r_src + CW'(1));
                wdata = rdata;
                if (r_src == r_pos) begin
                    n_state = S_INS_W;
                end else begin
                    n_src   = r_src - CW'(1);
                    n_state = S_SHU_R;
                end
            end
            S_INS_W: begin
                we       = 1'b1;
                waddr    = IW'(r_pos);
                wdata    = r_ins;
                n_count  = r_count + CW'(1);
                n_status = ST_OK;
                n_state  = S_DONE;
            end
            S_DONE: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_count <= CW'(1);
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
        r_op         <= n_op;
        r_s          <= n_s;
        r_len        <= n_len;
        r_e          <= n_e;
        r_idx        <= n_idx;
        r_has_prev   <= n_has_prev;
        r_prev_start <= n_prev_start;
        r_prev_len   <= n_prev_len;
        r_prev_end   <= n_prev_end;
        r_status     <= n_status;
        r_pos        <= n_pos;
        r_src        <= n_src;
        r_ins        <= n_ins;
    end

    assign o_idle          = (r_state == S_IDLE);
    assign o_result.done   = (r_state == S_DONE) && i_out_free;
    assign o_result.status = r_status;
    assign o_count         = r_count;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_RANGES))
        else $error("range count exceeds table depth");

    a_done_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.done |=> r_state == S_IDLE)
        else $error("sequencer did not return to idle after a result");

    a_scan_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SCAN |-> r_idx <= r_count)
        else $error("scan index ran past the range count");

endmodule

FILE: design/free_range_table_allocator.sv
// ----------------------------------------------------------------------------
// free_range_table_allocator
// Address-ordered table of free ranges with allocate, free and coalescing.
//
//   Channel   Direction  Handshake              Payload
//   in        input      i_in_valid/o_in_stall  opcode, start_addr, length
//   out       output     o_out_valid/i_out_stall status, range_count
//   cfg       input      i_cfg_valid/o_cfg_ready total_size
//
// A request is taken in idle; unless it is refused there at once, the scan then visits
// the table entries in order, each entry moved when a range is inserted or removed
// passes through a read and a write state, and the request ends in done.
// After reset the init state writes the initial range before requests are taken.
// A result waits in the output register while the next request is taken.
// ----------------------------------------------------------------------------
module free_range_table_allocator #(
    parameter int MAX_RANGES = 16,
    parameter int ADDR_BITS  = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_opcode,
    input  logic [ADDR_BITS-1:0]            i_start_addr,
    input  logic [ADDR_BITS:0]              i_length,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output fra_pkg::t_status                o_status,
    output logic [$clog2(MAX_RANGES+1)-1:0] o_range_count,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [fra_pkg::CFG_BITS-1:0]    i_cfg_data
);

    import fra_pkg::*;

    localparam int LW   = ADDR_BITS + 1;
    localparam int CW   = $clog2(MAX_RANGES + 1);
    localparam int CMPW = (LW > CFG_BITS) ? LW : CFG_BITS;
    localparam logic [CMPW-1:0] SPACE_X = CMPW'(1) << ADDR_BITS;
    localparam logic [CMPW-1:0] RESET_X = (ADDR_BITS >= 16) ? CMPW'(65536) : SPACE_X;

    logic [LW-1:0] r_total;
    logic          r_out_valid;
    t_status       r_status;
    logic [CW-1:0] r_range_count;

    logic          idle;
    logic          out_free;
    logic          cfg_we;
    logic          start;
    logic [CMPW-1:0] cfg_x;
    logic [LW-1:0] cfg_total;
    t_result       result;
    logic [CW-1:0] count;

    assign cfg_x     = CMPW'(i_cfg_data);
    assign cfg_total = (cfg_x > SPACE_X) ? LW'(SPACE_X) : LW'(cfg_x);
    assign cfg_we    = i_cfg_valid && o_cfg_ready;
    assign start     = i_in_valid && !o_in_stall;
    assign out_free  = !r_out_valid || !i_out_stall;

    fra_seq #(
        .MAX_RANGES (MAX_RANGES),
        .ADDR_BITS  (ADDR_BITS)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_opcode     (i_opcode),
        .i_start_addr (i_start_addr),
        .i_length     (i_length),
        .i_total      (r_total),
        .i_cfg_we     (cfg_we),
        .i_cfg_total  (cfg_total),
        .i_out_free   (out_free),
        .o_idle       (idle),
        .o_result     (result),
        .o_count      (count)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total     <= LW'(RESET_X);
            r_out_valid <= 1'b0;
        end else begin
            if (cfg_we) begin
                r_total <= cfg_total;
            end
            if (result.done) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        if (result.done) begin
            r_status      <= result.status;
            r_range_count <= count;
        end
    end

    assign o_in_stall    = !idle || i_cfg_valid;
    assign o_cfg_ready   = idle;
    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_range_count = r_range_count;

endmodule

FILE: tb/tb_free_range_table_allocator.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_free_range_table_allocator
// Self-checking testbench for the free range table allocator. A model of the
// address-ordered free table predicts status and range count for every
// request; results are compared in order. Directed edge cases are followed
// by random allocate and free traffic under several total sizes.
// ----------------------------------------------------------------------------
module tb_free_range_table_allocator;

    import fra_pkg::*;

    localparam int NRANGE = 16;
    localparam int SPACE  = 65536;

    typedef struct packed {
        t_status    status;
        logic [4:0] count;
    } t_outcome;

    class range_scoreboard;
        int unsigned total;
        int unsigned rstart [NRANGE];
        int unsigned rlen [NRANGE];
        int          nfree;
        t_outcome    pending [$];
        int          mismatches;
        int          checked;

        function void reinit(int unsigned size);
            int k;
            total = (size > SPACE) ? SPACE : size;
            for (k = 0; k < NRANGE; k++) begin
                rstart[k] = 0;
                rlen[k] = 0;
            end
            nfree = (total == 0) ? 0 : 1;
            rlen[0] = total;
        endfunction

        function void drop_entry(int pos);
            int k;
            for (k = pos; k + 1 < nfree; k++) begin
                rstart[k] = rstart[k+1];
                rlen[k] = rlen[k+1];
            end
            nfree--;
            rstart[nfree] = 0;
            rlen[nfree] = 0;
        endfunction

        function void add_entry(int pos, int unsigned s, int unsigned l);
            int k;
            for (k = nfree; k > pos; k--) begin
                rstart[k] = rstart[k-1];
                rlen[k] = rlen[k-1];
            end
            rstart[pos] = s;
            rlen[pos] = l;
            nfree++;
        endfunction

        function t_status carve(int unsigned s, int unsigned len);
            int i;
            int unsigned e, rs, re;
            e = s + len;
            if (len == 0) return ST_NOT_INSIDE;
            for (i = 0; i < nfree; i++)
                if (s >= rstart[i] && s < rstart[i] + rlen[i]) break;
            if (i >= nfree) return ST_NOT_INSIDE;
            rs = rstart[i];
            re = rs + rlen[i];
            if (e > re) return ST_NOT_INSIDE;
            if (s == rs && e == re) drop_entry(i);
            else if (s == rs) begin
                rstart[i] = e;
                rlen[i] -= len;
            end else if (e == re) rlen[i] -= len;
            else begin
                if (nfree >= NRANGE) return ST_FULL;
                rlen[i] = s - rs;
                add_entry(i + 1, e, re - e);
            end
            return ST_OK;
        endfunction

        function t_status give_back(int unsigned s, int unsigned len);
            int i;
            int unsigned e, bend;
            bit hb, hc, ab, ac;
            i = 0;
            bend = 0;
            e = s + len;
            if (len == 0 || e > total) return ST_NOT_INSIDE;
            while (i < nfree && s > rstart[i]) i++;
            hb = (i > 0);
            if (hb) bend = rstart[i-1] + rlen[i-1];
            hc = (i < nfree);
            if (hb && bend > s) return ST_OVERLAP;
            if (hc && e > rstart[i]) return ST_OVERLAP;
            ab = hb && bend == s;
            ac = hc && e == rstart[i];
            if (ab && ac) begin
                rlen[i-1] += len + rlen[i];
                drop_entry(i);
            end else if (ab) rlen[i-1] += len;
            else if (ac) begin
                rstart[i] = s;
                rlen[i] += len;
            end else begin
                if (nfree >= NRANGE) return ST_FULL;
                add_entry(i, s, len);
            end
            return ST_OK;
        endfunction

        function void note_request(logic op, int unsigned s, int unsigned len);
            t_outcome o;
            o.status = (op == OP_ALLOC) ? carve(s, len) : give_back(s, len);
            o.count = nfree[4:0];
            pending.push_back(o);
        endfunction

        function void check_result(t_status st, logic [4:0] cnt);
            t_outcome o;
            checked++;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result: status %0d count %0d", st, cnt);
                return;
            end
            o = pending.pop_front();
            if (o.status !== st || o.count !== cnt) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Mismatch: expected status %0d count %0d, got %0d %0d",
                             o.status, o.count, st, cnt);
            end
        endfunction
    endclass

    logic        clk = 0;
    logic        rst_n = 0;
    logic        in_valid = 0;
    logic        in_stall;
    logic        opcode = 0;
    logic [15:0] start_addr = 0;
    logic [16:0] length = 0;
    logic        out_valid;
    logic        out_stall = 0;
    t_status     status;
    logic [4:0]  range_count;
    logic        cfg_valid = 0;
    logic        cfg_ready;
    logic [16:0] cfg_data = 0;

    range_scoreboard sb;
    int          hold_off_cycles = 0;
    bit          hold_request = 0;
    bit          hold_taken = 0;
    bit          stall_random = 1;
    int          sent = 0;

    always #6 clk = ~clk;

    free_range_table_allocator #(.MAX_RANGES(16), .ADDR_BITS(16)) u_top (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall),
        .i_opcode(opcode), .i_start_addr(start_addr), .i_length(length),
        .o_out_valid(out_valid), .i_out_stall(out_stall),
        .o_status(status), .o_range_count(range_count),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready), .i_cfg_data(cfg_data)
    );

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Receiver: random stalls, plus an explicit long hold-off when requested.
    always @(posedge clk) begin
        if (out_valid && !out_stall && rst_n)
            sb.check_result(status, range_count);
        if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            out_stall <= 1'b1;
        end else if (hold_request && !hold_taken) begin
            hold_off_cycles <= 200;
            hold_taken <= 1'b1;
            out_stall <= 1'b1;
        end else if (stall_random)
            out_stall <= ($urandom_range(0, 99) < 25);
        else
            out_stall <= 1'b0;
    end

    task automatic send_request(logic op, int unsigned s, int unsigned len);
        int g;
        g = gap_len();
        if (g > 0) begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode <= op;
        start_addr <= s[15:0];
        length <= len[16:0];
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_request(op, s, len);
        sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_size(int unsigned v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= v[16:0];
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        sb.reinit(v & 17'h1FFFF);
        @(posedge clk);
    endtask

    task automatic random_phase(int n, int unsigned size);
        int k;
        int unsigned s, len, lim;
        lim = (size == 0) ? 1 : size;
        for (k = 0; k < n; k++) begin
            if ($urandom_range(0, 9) == 0) begin
                s = $urandom_range(0, 65535);
                len = $urandom_range(0, 131071);
            end else begin
                s = $urandom_range(0, lim - 1);
                len = $urandom_range(0, 9) < 7 ? $urandom_range(1, 1 + lim / 32)
                                               : $urandom_range(0, lim);
                if (sb.nfree > 0 && $urandom_range(0, 2) == 0) begin
                    int j;
                    j = $urandom_range(0, sb.nfree - 1);
                    s = sb.rstart[j] + $urandom_range(0, 1) * (sb.rlen[j] / 2);
                    len = $urandom_range(1, (sb.rlen[j] + 1) / 2);
                end
            end
            send_request(($urandom_range(0, 1) == 1) ? OP_FREE : OP_ALLOC, s, len);
        end
    endtask

    initial begin
        sb = new();
        sb.reinit(SPACE);
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // Directed: extremes, zero length, splits, merges, overlaps.
        send_request(OP_ALLOC, 0, 0);
        send_request(OP_FREE, 0, 0);
        send_request(OP_ALLOC, 0, 65536);
        send_request(OP_ALLOC, 0, 1);
        send_request(OP_FREE, 0, 65536);
        send_request(OP_FREE, 65535, 1);
        send_request(OP_FREE, 65535, 2);
        send_request(OP_ALLOC, 65535, 1);
        send_request(OP_ALLOC, 65535, 2);
        send_request(OP_ALLOC, 100, 10);
        send_request(OP_FREE, 105, 2);
        send_request(OP_FREE, 100, 5);
        send_request(OP_FREE, 107, 3);
        for (int k = 0; k < 17; k++) send_request(OP_ALLOC, 1000 + 4 * k, 2);
        send_request(OP_FREE, 1002, 1);
        write_size(0);
        send_request(OP_ALLOC, 0, 1);
        send_request(OP_FREE, 0, 1);
        write_size(17'h1FFFF);
        send_request(OP_FREE, 65535, 1);
        write_size(1);
        send_request(OP_ALLOC, 0, 1);
        send_request(OP_FREE, 0, 1);
        // Long receiver hold-off while the sender keeps offering.
        write_size(256);
        hold_request = 1'b1;
        random_phase(20, 256);
        drain();
        random_phase(300, 256);
        write_size(40);
        random_phase(250, 40);
        write_size(65536);
        stall_random = 0;
        random_phase(150, 65536);
        stall_random = 1;
        write_size(4096);
        random_phase(250, 4096);
        write_size(17);
        random_phase(250, 17);
        drain();
        $display("Ran %0d requests under total sizes 0, 1, 17, 40, 256, 4096 and 65536,",
                 sent);
        $display("with %0d results checked and long back-pressure stretches.", sb.checked);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial begin
        #20ms;
        $display("FAILURE");
        $finish;
    end

endmodule

FILE: sim.f
design/fra_pkg.sv
design/fra_mem.sv
design/fra_seq.sv
design/free_range_table_allocator.sv
tb/tb_free_range_table_allocator.sv
